[design/drl_pkg.sv]
`default_nettype none

package drl_pkg;

  localparam int DRL_MAX_FIELD_BYTES = 8;

  localparam int CLUSTERS_W = 64;
  localparam int START_W = 63;
  localparam int STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_RUN       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LIST_END  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_HDR   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

  typedef struct packed {
    logic [CLUSTERS_W-1:0] run_clusters;
    logic [START_W-1:0]    run_start_cluster;
    logic                  sparse_run;
    logic [STATUS_W-1:0]   status;
    logic                  list_done;
  } result_t;

endpackage

`default_nettype wire

[design/data_run_list_decoder.sv]
`default_nettype none

// Streaming decoder for a file-system data run list. Bytes of the list enter on
// the s_ side, one per transaction, with s_tlast on the last byte of the list
// region; each decoded run, list end or error leaves on the m_ side, with m_tlast
// set on the transaction that closes the list. A consumer should drop the runs of
// any list whose closing transaction carries an error status. The block takes one
// byte per cycle: a byte is captured in an input register and then decoded by a
// single pass of merge, sign-extend and one 64-bit add into a four-entry result
// queue. Only a run finished on the region's last byte makes two results, so the
// queue only throttles s_tready when m_tready is held low.
module data_run_list_decoder import drl_pkg::*; #(
  parameter int MAX_FIELD_BYTES = DRL_MAX_FIELD_BYTES
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // data_byte
  input  wire logic         s_tlast,   // final_byte
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata,   // run_clusters [63:0], run_start_cluster [126:64], zero
  output logic [3:0]        m_tuser,   // sparse_run [0], status [3:1]
  output logic              m_tlast    // list_done
);

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_final;
  logic       stage_fire;
  logic       room;
  logic       res0_valid;
  logic       res1_valid;
  result_t    res0;
  result_t    res1;
  result_t    out_data;

  assign stage_fire = stage_valid && room;
  assign s_tready   = !stage_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_byte  <= s_tdata;
      stage_final <= s_tlast;
    end
  end

  drl_core #(
    .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step_valid (stage_fire),
    .step_byte  (stage_byte),
    .step_final (stage_final),
    .res0_valid (res0_valid),
    .res0       (res0),
    .res1_valid (res1_valid),
    .res1       (res1)
  );

  drl_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push0     (res0_valid),
    .data0     (res0),
    .push1     (res1_valid),
    .data1     (res1),
    .room      (room),
    .out_valid (m_tvalid),
    .out_data  (out_data),
    .out_ready (m_tready)
  );

  assign m_tdata = {1'b0, out_data.run_start_cluster, out_data.run_clusters};
  assign m_tuser = {out_data.status, out_data.sparse_run};
  assign m_tlast = out_data.list_done;

endmodule

`default_nettype wire

[design/drl_core.sv]
`default_nettype none

module drl_core import drl_pkg::*; #(
  parameter int MAX_FIELD_BYTES = DRL_MAX_FIELD_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step_valid,
  input  wire logic [7:0] step_byte,
  input  wire logic       step_final,
  output logic            res0_valid,
  output result_t         res0,
  output logic            res1_valid,
  output result_t         res1
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_COUNT  = 2'd1;
  localparam logic [1:0] PH_DELTA  = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  localparam logic [3:0] MAX_BYTES = 4'(MAX_FIELD_BYTES);

  logic [1:0]  phase, phase_next;
  logic [3:0]  length_bytes, length_bytes_next;
  logic [3:0]  offset_bytes, offset_bytes_next;
  logic [3:0]  byte_position, byte_position_next;
  logic [63:0] count_acc, count_acc_next;
  logic [63:0] delta_acc, delta_acc_next;
  logic [62:0] current_cluster, current_cluster_next;

  logic [63:0] count_merged;
  logic [63:0] delta_merged;
  logic [63:0] delta_ext;
  logic [63:0] start_sum;
  logic [3:0]  pos_inc;
  logic [3:0]  hdr_lb;
  logic [3:0]  hdr_ob;
  logic [6:0]  sign_pos;
  logic        delta_sign;
  logic        clear_all;
  logic        done_run;

  assign pos_inc = byte_position + 4'd1;
  assign hdr_lb = step_byte[3:0];
  assign hdr_ob = step_byte[7:4];
  assign sign_pos = {offset_bytes, 3'b000} - 7'd1;
  assign delta_sign = delta_merged[sign_pos[5:0]];

  // Each incoming field byte lands in its own lane of the little-endian accumulator.
  always_comb begin
    count_merged = count_acc;
    delta_merged = delta_acc;
    count_merged[{byte_position[2:0], 3'b000} +: 8] =
      count_acc[{byte_position[2:0], 3'b000} +: 8] | step_byte;
    delta_merged[{byte_position[2:0], 3'b000} +: 8] =
      delta_acc[{byte_position[2:0], 3'b000} +: 8] | step_byte;
  end

  always_comb begin
    delta_ext = delta_merged;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) >= offset_bytes && delta_sign) begin
        delta_ext[8*i +: 8] = 8'hFF;
      end
    end
  end

  // The running cluster is never negative, so bit 63 of the sum flags both
  // signed overflow and a negative start.
  assign start_sum = {1'b0, current_cluster} + delta_ext;

  always_comb begin
    phase_next           = phase;
    length_bytes_next    = length_bytes;
    offset_bytes_next    = offset_bytes;
    byte_position_next   = byte_position;
    count_acc_next       = count_acc;
    delta_acc_next       = delta_acc;
    current_cluster_next = current_cluster;
    clear_all            = 1'b0;
    done_run             = 1'b0;
    res0_valid           = 1'b0;
    res1_valid           = 1'b0;
    res0                 = '0;
    res1                 = '0;
    res1.status          = ST_TRUNCATED;
    res1.list_done       = 1'b1;
    res0.list_done       = 1'b1;

    if (step_valid) begin
      case (phase)
        PH_HEADER: begin
          if (step_byte == 8'd0) begin
            res0_valid  = 1'b1;
            res0.status = ST_LIST_END;
          end else if (hdr_lb == 4'd0 || hdr_lb > MAX_BYTES || hdr_ob > MAX_BYTES) begin
            res0_valid  = 1'b1;
            res0.status = ST_BAD_HDR;
          end else if (step_final) begin
            res0_valid  = 1'b1;
            res0.status = ST_TRUNCATED;
          end else begin
            length_bytes_next  = hdr_lb;
            offset_bytes_next  = hdr_ob;
            byte_position_next = 4'd0;
            count_acc_next     = '0;
            delta_acc_next     = '0;
            phase_next         = PH_COUNT;
          end
        end
        PH_COUNT: begin
          count_acc_next     = count_merged;
          byte_position_next = pos_inc;
          if (pos_inc >= length_bytes) begin
            if (offset_bytes == 4'd0) begin
              done_run = 1'b1;
            end else begin
              byte_position_next = 4'd0;
              phase_next         = PH_DELTA;
            end
          end
          if (!done_run && step_final) begin
            res0_valid  = 1'b1;
            res0.status = ST_TRUNCATED;
          end
        end
        PH_DELTA: begin
          delta_acc_next     = delta_merged;
          byte_position_next = pos_inc;
          if (pos_inc >= offset_bytes) begin
            done_run = 1'b1;
          end else if (step_final) begin
            res0_valid  = 1'b1;
            res0.status = ST_TRUNCATED;
          end
        end
        default: begin
          if (step_final) begin
            clear_all = 1'b1;
          end
        end
      endcase

      if (done_run) begin
        res0_valid = 1'b1;
        if (offset_bytes != 4'd0 && start_sum[63]) begin
          res0.status = ST_RANGE;
        end else begin
          res0.run_clusters = (phase == PH_COUNT) ? count_merged : count_acc;
          res0.sparse_run   = (offset_bytes == 4'd0);
          res0.status       = ST_RUN;
          res0.list_done    = 1'b0;
          if (offset_bytes != 4'd0) begin
            res0.run_start_cluster = start_sum[62:0];
            current_cluster_next   = start_sum[62:0];
          end
          count_acc_next     = '0;
          delta_acc_next     = '0;
          byte_position_next = 4'd0;
          phase_next         = PH_HEADER;
          res1_valid         = step_final;
        end
      end

      // Any result that closes the list sends the block to skip mode, and the
      // final byte of the region always starts a fresh list.
      if (res0_valid && res0.list_done) begin
        phase_next = PH_SKIP;
      end
      if (step_final) begin
        clear_all = 1'b1;
      end
    end

    if (clear_all) begin
      phase_next           = PH_HEADER;
      length_bytes_next    = 4'd0;
      offset_bytes_next    = 4'd0;
      byte_position_next   = 4'd0;
      count_acc_next       = '0;
      delta_acc_next       = '0;
      current_cluster_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      length_bytes    <= 4'd0;
      offset_bytes    <= 4'd0;
      byte_position   <= 4'd0;
      count_acc       <= '0;
      delta_acc       <= '0;
      current_cluster <= '0;
    end else begin
      phase           <= phase_next;
      length_bytes    <= length_bytes_next;
      offset_bytes    <= offset_bytes_next;
      byte_position   <= byte_position_next;
      count_acc       <= count_acc_next;
      delta_acc       <= delta_acc_next;
      current_cluster <= current_cluster_next;
    end
  end

endmodule

`default_nettype wire

[design/drl_result_fifo.sv]
`default_nettype none

module drl_result_fifo import drl_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push0,
  input  wire result_t data0,
  input  wire logic    push1,
  input  wire result_t data1,
  output logic         room,
  output logic         out_valid,
  output result_t      out_data,
  input  wire logic    out_ready
);

  result_t    entries [4];
  logic [1:0] wr_ptr, wr_ptr_next;
  logic [1:0] rd_ptr, rd_ptr_next;
  logic [2:0] fill, fill_next;
  logic       pop;
  logic [1:0] n_push;

  // Room means two free entries, enough for the largest burst one byte can make.
  assign room      = (fill <= 3'd2);
  assign out_valid = (fill != 3'd0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign n_push    = {1'b0, push0} + {1'b0, push1};

  always_comb begin
    wr_ptr_next = wr_ptr + n_push;
    rd_ptr_next = rd_ptr + {1'b0, pop};
    fill_next   = fill + {1'b0, n_push} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      entries[wr_ptr] <= data0;
    end
    if (push1) begin
      entries[wr_ptr + 2'd1] <= data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fill   <= fill_next;
    end
  end

endmodule

`default_nettype wire
